FILE: src/ip6ehc_pkg.sv
// Package: protocol codes, walk phases and beat types of the IPv6 extension header parser
`default_nettype none
package ip6ehc_pkg;

	localparam logic [7:0] PROTO_HOP   = 8'd0;
	localparam logic [7:0] PROTO_ROUTE = 8'd43;
	localparam logic [7:0] PROTO_FRAG  = 8'd44;
	localparam logic [7:0] PROTO_AH    = 8'd51;
	localparam logic [7:0] PROTO_DEST  = 8'd60;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WALK = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] start_proto;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  final_proto;
		logic [15:0] last_hdr_offset;
		logic        last_hdr_valid;
		logic [15:0] ext_total_bytes;
	} out_beat_t;

	function automatic logic is_ext(input logic [7:0] p);
		return (p == PROTO_HOP) || (p == PROTO_ROUTE) || (p == PROTO_FRAG) ||
			(p == PROTO_AH) || (p == PROTO_DEST);
	endfunction

endpackage
`default_nettype wire

FILE: src/ip6ehc_if.sv
// Valid/ready channel interfaces for packet byte beats and result beats
`default_nettype none
interface ip6ehc_in_if;
	logic                valid;
	logic                ready;
	ip6ehc_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ip6ehc_out_if;
	logic                 valid;
	logic                 ready;
	ip6ehc_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/ipv6_ext_header_chain_parser.sv
// IPv6 extension header chain parser: walks the header chain over a byte stream.
// Usage:
//   pkt carries one packet byte per beat, starting with the first byte after the
//   fixed header (first_byte = 1, start_proto = fixed header next-header) and
//   ending with last_byte = 1. Hop-by-hop, routing, fragment, AH and destination
//   headers are skipped; one result beat is sent on res when the chain ends
//   (upper protocol, non-first fragment, malformed or truncated header, end of
//   packet). Bytes after the end of the chain produce nothing.
//   Throughput: one byte per cycle while res is not stalled. A byte sits in the
//   input stage and is walked when the stage advances, where its result is
//   registered in the output register that drives res.valid.
//   Reset: the walker goes idle and ignores bytes until a first_byte beat.
//   Stall: a result waits in the output register while res.ready is low; the
//   input stage still fills, then pkt.ready drops until the result is taken.
//   Offset and total counters are OFFSET_BITS wide and saturate; results carry
//   their low 16 bits.
`default_nettype none
module ipv6_ext_header_chain_parser #(
	parameter int OFFSET_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	ip6ehc_in_if.sink    pkt,
	ip6ehc_out_if.source res
);

	localparam int CW = OFFSET_BITS;

	// input stage
	logic                  valid_s1;
	ip6ehc_pkg::in_beat_t  beat_s1;
	logic                  adv;

	// walker state
	logic [7:0]            cur_proto_q;
	logic [7:0]            pending_next_q;
	logic [10:0]           hdr_pos_q;
	logic [11:0]           hdr_len_q;
	logic [CW-1:0]         total_q;
	logic [CW-1:0]         last_off_q;
	logic                  seen_q;
	logic [7:0]            frag_high_q;
	ip6ehc_pkg::phase_t    phase_q;

	// next state
	logic [7:0]            n_proto;
	logic [7:0]            n_pend;
	logic [10:0]           n_pos;
	logic [11:0]           n_len;
	logic [CW-1:0]         n_total;
	logic [CW-1:0]         n_off;
	logic                  n_seen;
	logic [7:0]            n_fh;
	ip6ehc_pkg::phase_t    n_phase;
	logic                  emit;
	logic [7:0]            emit_proto;
	logic                  abort;
	logic [CW:0]           sum;

	// output register
	logic                  res_valid_q;
	ip6ehc_pkg::out_beat_t res_q;

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign pkt.ready = !valid_s1 || adv;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			beat_s1 <= pkt.data;
		end
	end

	always_comb begin
		n_proto    = cur_proto_q;
		n_pend     = pending_next_q;
		n_pos      = hdr_pos_q;
		n_len      = hdr_len_q;
		n_total    = total_q;
		n_off      = last_off_q;
		n_seen     = seen_q;
		n_fh       = frag_high_q;
		n_phase    = phase_q;
		emit       = 1'b0;
		emit_proto = 8'd0;
		abort      = 1'b0;
		sum        = '0;

		if (beat_s1.first_byte) begin
			n_total = '0;
			n_off   = '0;
			n_seen  = 1'b0;
			n_fh    = 8'd0;
			n_pos   = 11'd0;
			n_len   = 12'd0;
			n_pend  = 8'd0;
			n_proto = beat_s1.start_proto;
			n_phase = ip6ehc_pkg::PH_WALK;
		end

		if (beat_s1.first_byte && !ip6ehc_pkg::is_ext(beat_s1.start_proto)) begin
			emit       = 1'b1;
			emit_proto = beat_s1.start_proto;
			n_phase    = ip6ehc_pkg::PH_DONE;
		end else if (n_phase == ip6ehc_pkg::PH_WALK) begin
			priority if (n_pos == 11'd0) begin
				n_pend = beat_s1.data_byte;
			end else if (n_pos == 11'd1) begin
				priority if (n_proto == ip6ehc_pkg::PROTO_FRAG) begin
					if (beat_s1.data_byte != 8'd0) begin
						abort      = 1'b1;
						emit       = 1'b1;
						emit_proto = n_proto;
						n_phase    = ip6ehc_pkg::PH_DONE;
					end else begin
						n_len = 12'd8;
					end
				end else if (n_proto == ip6ehc_pkg::PROTO_AH) begin
					n_len = {2'b00, beat_s1.data_byte, 2'b00} + 12'd8;
				end else begin
					n_len = {1'b0, beat_s1.data_byte, 3'b000} + 12'd8;
				end
			end else if (n_pos == 11'd2) begin
				n_fh = beat_s1.data_byte;
			end else if (n_pos == 11'd3) begin
				n_fh = ((n_fh != 8'd0) || (beat_s1.data_byte[7:3] != 5'd0)) ? 8'd1 : 8'd0;
			end else begin
				n_fh = n_fh;
			end

			if (!abort) begin
				if ((n_pos != 11'd0) && (({1'b0, n_pos} + 12'd1) == n_len)) begin
					// header complete
					sum     = {1'b0, n_total} + (CW+1)'(n_len);
					n_off   = n_total;
					n_seen  = 1'b1;
					n_total = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
					n_pos   = 11'd0;
					if ((n_proto == ip6ehc_pkg::PROTO_FRAG) && (n_fh != 8'd0)) begin
						emit       = 1'b1;
						emit_proto = n_pend;
						n_phase    = ip6ehc_pkg::PH_DONE;
					end else begin
						n_proto = n_pend;
						if (!ip6ehc_pkg::is_ext(n_pend) || beat_s1.last_byte) begin
							emit       = 1'b1;
							emit_proto = n_pend;
							n_phase    = ip6ehc_pkg::PH_DONE;
						end
					end
				end else begin
					n_pos = n_pos + 11'd1;
					if (beat_s1.last_byte) begin
						emit       = 1'b1;
						emit_proto = n_proto;
						n_phase    = ip6ehc_pkg::PH_DONE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_proto_q    <= 8'd0;
			pending_next_q <= 8'd0;
			hdr_pos_q      <= 11'd0;
			hdr_len_q      <= 12'd0;
			total_q        <= '0;
			last_off_q     <= '0;
			seen_q         <= 1'b0;
			frag_high_q    <= 8'd0;
			phase_q        <= ip6ehc_pkg::PH_IDLE;
		end else if (adv) begin
			cur_proto_q    <= n_proto;
			pending_next_q <= n_pend;
			hdr_pos_q      <= n_pos;
			hdr_len_q      <= n_len;
			total_q        <= n_total;
			last_off_q     <= n_off;
			seen_q         <= n_seen;
			frag_high_q    <= n_fh;
			phase_q        <= n_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q.final_proto     <= emit_proto;
			res_q.last_hdr_offset <= n_seen ? 16'(n_off) : 16'd0;
			res_q.last_hdr_valid  <= n_seen;
			res_q.ext_total_bytes <= 16'(n_total);
		end
	end

	// checks
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> phase_q == ip6ehc_pkg::PH_DONE)
		else $error("walker not done after result");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ip6ehc_pkg::PH_IDLE |-> !seen_q && (total_q == '0))
		else $error("idle walker holds header state");

	a_off_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> last_off_q <= total_q)
		else $error("last header offset beyond total");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(beat_s1))
		else $error("stalled input stage lost its byte");

endmodule
`default_nettype wire

FILE: verif/ipv6_ext_header_chain_parser_tb.sv
// Testbench: walks random and directed IPv6 extension header chains through the parser
`timescale 1ns / 1ps
module ipv6_ext_header_chain_parser_tb;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEM_COUNT = 1900;

	logic clk = 1'b0;
	logic arst_n;

	ip6ehc_in_if  pkt_if();
	ip6ehc_out_if res_if();

	ipv6_ext_header_chain_parser #(
		.OFFSET_BITS(16)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_if),
		.res    (res_if)
	);

	always #5 clk = ~clk;

	// chain walker state
	ip6ehc_pkg::phase_t walk_phase = ip6ehc_pkg::PH_IDLE;
	logic [7:0]  cur_hdr = '0;
	logic [7:0]  next_hdr = '0;
	logic [10:0] hdr_idx = '0;
	logic [11:0] hdr_size = '0;
	logic [15:0] ext_total = '0;
	logic [15:0] last_off = '0;
	logic        off_valid = 1'b0;
	logic [7:0]  frag_word = '0;

	ip6ehc_pkg::out_beat_t chain_results_q[$];
	logic [7:0]  pkt_bytes[$];
	int          cycle_count = 0;
	int          error_count = 0;
	int          sent_count = 0;
	int          hold_req = 0;
	bit          no_idle = 1'b0;

	function automatic bit chain_hdr(input logic [7:0] p);
		return p == ip6ehc_pkg::PROTO_HOP || p == ip6ehc_pkg::PROTO_ROUTE ||
			p == ip6ehc_pkg::PROTO_FRAG || p == ip6ehc_pkg::PROTO_AH ||
			p == ip6ehc_pkg::PROTO_DEST;
	endfunction

	function automatic bit end_chain(input logic [7:0] proto,
			output ip6ehc_pkg::out_beat_t r);
		r.final_proto = proto;
		r.last_hdr_offset = off_valid ? last_off : 16'd0;
		r.last_hdr_valid = off_valid;
		r.ext_total_bytes = ext_total;
		walk_phase = ip6ehc_pkg::PH_DONE;
		return 1'b1;
	endfunction

	function automatic bit walk_byte(input ip6ehc_pkg::in_beat_t b,
			output ip6ehc_pkg::out_beat_t r);
		logic [16:0] sum;
		r = '0;
		if (b.first_byte) begin
			ext_total = '0;
			last_off = '0;
			off_valid = 1'b0;
			frag_word = '0;
			hdr_idx = '0;
			hdr_size = '0;
			next_hdr = '0;
			cur_hdr = b.start_proto;
			walk_phase = ip6ehc_pkg::PH_WALK;
			if (!chain_hdr(cur_hdr))
				return end_chain(cur_hdr, r);
		end
		if (walk_phase != ip6ehc_pkg::PH_WALK)
			return 1'b0;
		unique case (hdr_idx)
			11'd0: next_hdr = b.data_byte;
			11'd1: begin
				if (cur_hdr == ip6ehc_pkg::PROTO_FRAG) begin
					if (b.data_byte != 8'd0)
						return end_chain(cur_hdr, r);
					hdr_size = 12'd8;
				end else if (cur_hdr == ip6ehc_pkg::PROTO_AH) begin
					hdr_size = {2'b00, b.data_byte, 2'b00} + 12'd8;
				end else begin
					hdr_size = {1'b0, b.data_byte, 3'b000} + 12'd8;
				end
			end
			11'd2: frag_word = b.data_byte;
			11'd3: frag_word = (frag_word != 8'd0 || b.data_byte[7:3] != 5'd0) ? 8'd1 : 8'd0;
			default: ;
		endcase
		if (hdr_idx >= 11'd1 && {1'b0, hdr_idx} + 12'd1 == hdr_size) begin
			sum = {1'b0, ext_total} + {5'd0, hdr_size};
			last_off = ext_total;
			off_valid = 1'b1;
			ext_total = sum[16] ? 16'hFFFF : sum[15:0];
			hdr_idx = '0;
			if (cur_hdr == ip6ehc_pkg::PROTO_FRAG && frag_word != 8'd0)
				return end_chain(next_hdr, r);
			cur_hdr = next_hdr;
			if (!chain_hdr(cur_hdr) || b.last_byte)
				return end_chain(cur_hdr, r);
			return 1'b0;
		end
		hdr_idx = hdr_idx + 11'd1;
		if (b.last_byte)
			return end_chain(cur_hdr, r);
		return 1'b0;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input ip6ehc_pkg::in_beat_t b);
		int gap;
		ip6ehc_pkg::out_beat_t r;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			pkt_if.valid <= 1'b0;
		end
		@(negedge clk);
		pkt_if.valid <= 1'b1;
		pkt_if.data <= b;
		do @(posedge clk); while (!pkt_if.ready);
		sent_count++;
		if (walk_byte(b, r))
			chain_results_q.push_back(r);
	endtask

	task automatic send_packet(input logic [7:0] sp, input bit ends);
		ip6ehc_pkg::in_beat_t b;
		for (int i = 0; i < pkt_bytes.size(); i++) begin
			b.data_byte = pkt_bytes[i];
			b.first_byte = (i == 0);
			b.last_byte = ends && (i == pkt_bytes.size() - 1);
			b.start_proto = (i == 0) ? sp : 8'($urandom);
			send_byte(b);
		end
		pkt_bytes.delete();
	endtask

	task automatic add_hdr(input logic [7:0] kind, input logic [7:0] nxt,
			input logic [7:0] len_f, input logic [12:0] frag_off);
		int size;
		logic [7:0] v;
		size = (kind == ip6ehc_pkg::PROTO_FRAG) ? 8 :
			(kind == ip6ehc_pkg::PROTO_AH) ? 4 * len_f + 8 : 8 * len_f + 8;
		pkt_bytes.push_back(nxt);
		pkt_bytes.push_back(len_f);
		for (int i = 2; i < size; i++) begin
			v = 8'($urandom);
			if (kind == ip6ehc_pkg::PROTO_FRAG && i == 2)
				v = frag_off[12:5];
			if (kind == ip6ehc_pkg::PROTO_FRAG && i == 3)
				v = {frag_off[4:0], v[2:0]};
			pkt_bytes.push_back(v);
		end
	endtask

	task automatic cut_packet(input int keep);
		while (pkt_bytes.size() > keep)
			void'(pkt_bytes.pop_back());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		pkt_if.valid <= 1'b0;
		while (chain_results_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls plus requested long hold-offs
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		ip6ehc_pkg::out_beat_t exp_r;
		ip6ehc_pkg::out_beat_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (chain_results_q.size() == 0) begin
				$error("unexpected result beat: final_proto %0d", got.final_proto);
				error_count++;
			end else begin
				exp_r = chain_results_q.pop_front();
				if (got.final_proto !== exp_r.final_proto) begin
					$error("final_proto: expected %0d, got %0d", exp_r.final_proto,
						got.final_proto);
					error_count++;
				end
				if (got.last_hdr_offset !== exp_r.last_hdr_offset) begin
					$error("last_hdr_offset: expected %0d, got %0d", exp_r.last_hdr_offset,
						got.last_hdr_offset);
					error_count++;
				end
				if (got.last_hdr_valid !== exp_r.last_hdr_valid) begin
					$error("last_hdr_valid: expected %0d, got %0d", exp_r.last_hdr_valid,
						got.last_hdr_valid);
					error_count++;
				end
				if (got.ext_total_bytes !== exp_r.ext_total_bytes) begin
					$error("ext_total_bytes: expected %0d, got %0d", exp_r.ext_total_bytes,
						got.ext_total_bytes);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL ipv6_ext_header_chain_parser");
			$finish;
		end
	end

	task automatic test_ignored_before_start();
		ip6ehc_pkg::in_beat_t b;
		b.data_byte = 8'hFF;
		b.first_byte = 1'b0;
		b.last_byte = 1'b1;
		b.start_proto = 8'd6;
		send_byte(b);
		b.data_byte = 8'h00;
		b.last_byte = 1'b0;
		send_byte(b);
	endtask

	task automatic test_upper_at_start();
		pkt_bytes.push_back(8'hFF);
		send_packet(8'd6, 1'b1);
		pkt_bytes.push_back(8'h00);
		pkt_bytes.push_back(8'h11);
		send_packet(8'hFF, 1'b1);
	endtask

	task automatic test_every_header();
		add_hdr(ip6ehc_pkg::PROTO_HOP, ip6ehc_pkg::PROTO_ROUTE, 8'd0, 13'd0);
		add_hdr(ip6ehc_pkg::PROTO_ROUTE, ip6ehc_pkg::PROTO_FRAG, 8'd0, 13'd0);
		add_hdr(ip6ehc_pkg::PROTO_FRAG, ip6ehc_pkg::PROTO_AH, 8'd0, 13'd0);
		add_hdr(ip6ehc_pkg::PROTO_AH, ip6ehc_pkg::PROTO_DEST, 8'd1, 13'd0);
		add_hdr(ip6ehc_pkg::PROTO_DEST, 8'd6, 8'd0, 13'd0);
		pkt_bytes.push_back(8'hAB);
		send_packet(ip6ehc_pkg::PROTO_HOP, 1'b1);
	endtask

	task automatic test_fragments();
		// non-first: offset bit in byte 3, then in bytes 2 and 3
		add_hdr(ip6ehc_pkg::PROTO_FRAG, 8'd17, 8'd0, 13'd1);
		pkt_bytes.push_back(8'h55);
		send_packet(ip6ehc_pkg::PROTO_FRAG, 1'b1);
		add_hdr(ip6ehc_pkg::PROTO_FRAG, ip6ehc_pkg::PROTO_HOP, 8'd0, 13'h1FFF);
		send_packet(ip6ehc_pkg::PROTO_FRAG, 1'b1);
		// malformed: reserved byte nonzero
		add_hdr(ip6ehc_pkg::PROTO_FRAG, 8'd17, 8'hFF, 13'd0);
		send_packet(ip6ehc_pkg::PROTO_FRAG, 1'b1);
	endtask

	task automatic test_truncated();
		add_hdr(ip6ehc_pkg::PROTO_ROUTE, 8'd6, 8'd1, 13'd0);
		cut_packet(5);
		send_packet(ip6ehc_pkg::PROTO_ROUTE, 1'b1);
		pkt_bytes.push_back(8'h3A);
		send_packet(ip6ehc_pkg::PROTO_HOP, 1'b1);
		// header done on the last byte, next is still a chain header
		add_hdr(ip6ehc_pkg::PROTO_HOP, ip6ehc_pkg::PROTO_DEST, 8'd0, 13'd0);
		send_packet(ip6ehc_pkg::PROTO_HOP, 1'b1);
	endtask

	task automatic test_restart_mid_packet();
		add_hdr(ip6ehc_pkg::PROTO_DEST, 8'd6, 8'd2, 13'd0);
		cut_packet(3);
		send_packet(ip6ehc_pkg::PROTO_DEST, 1'b0);
		add_hdr(ip6ehc_pkg::PROTO_AH, 8'd59, 8'd0, 13'd0);
		send_packet(ip6ehc_pkg::PROTO_AH, 1'b1);
	endtask

	task automatic test_long_headers();
		no_idle = 1'b1;
		add_hdr(ip6ehc_pkg::PROTO_HOP, ip6ehc_pkg::PROTO_AH, 8'd31, 13'd0);
		add_hdr(ip6ehc_pkg::PROTO_AH, 8'd6, 8'd40, 13'd0);
		send_packet(ip6ehc_pkg::PROTO_HOP, 1'b1);
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_req = 300;
		for (int i = 0; i < 40; i++) begin
			pkt_bytes.push_back(8'($urandom));
			send_packet(8'd17, 1'b1);
		end
		wait_drained();
	endtask

	task automatic random_packet();
		logic [7:0] kinds[$];
		logic [7:0] kind_set[5];
		logic [7:0] upper;
		logic [7:0] sp;
		logic [7:0] len_f;
		logic [12:0] foff;
		int n;
		int r;
		bit ends;
		kind_set = '{ip6ehc_pkg::PROTO_HOP, ip6ehc_pkg::PROTO_ROUTE, ip6ehc_pkg::PROTO_FRAG,
			ip6ehc_pkg::PROTO_AH, ip6ehc_pkg::PROTO_DEST};
		no_idle = ($urandom_range(0, 99) < 15);
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++)
			kinds.push_back(kind_set[$urandom_range(0, 4)]);
		do upper = 8'($urandom); while (chain_hdr(upper));
		sp = (n > 0) ? kinds[0] : upper;
		if ($urandom_range(0, 99) < 5)
			sp = 8'($urandom);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 999);
			len_f = (r < 700) ? 8'd0 : (r < 900) ? 8'($urandom_range(1, 3)) :
				(r < 990) ? 8'($urandom_range(4, 15)) : 8'($urandom_range(16, 63));
			foff = 13'd0;
			if (kinds[i] == ip6ehc_pkg::PROTO_FRAG) begin
				len_f = ($urandom_range(0, 99) < 5) ? 8'($urandom_range(1, 255)) : 8'd0;
				if ($urandom_range(0, 99) < 20)
					foff = 13'($urandom_range(1, 8191));
			end
			add_hdr(kinds[i], (i + 1 < n) ? kinds[i + 1] : upper, len_f, foff);
		end
		repeat ($urandom_range(0, 4))
			pkt_bytes.push_back(8'($urandom));
		if (pkt_bytes.size() == 0)
			pkt_bytes.push_back(8'($urandom));
		r = $urandom_range(0, 99);
		ends = 1'b1;
		if (r < 12)
			cut_packet($urandom_range(1, pkt_bytes.size()));
		else if (r < 17)
			ends = 1'b0;
		send_packet(sp, ends);
		no_idle = 1'b0;
	endtask

	task automatic test_random_chains();
		while (sent_count < ITEM_COUNT)
			random_packet();
	endtask

	initial begin
		arst_n = 1'b0;
		pkt_if.valid = 1'b0;
		pkt_if.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_ignored_before_start();
		test_upper_at_start();
		test_every_header();
		test_fragments();
		test_truncated();
		test_restart_mid_packet();
		test_long_headers();
		test_backpressure();
		test_random_chains();
		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("PASS ipv6_ext_header_chain_parser");
		else
			$display("FAIL ipv6_ext_header_chain_parser");
		$finish;
	end

endmodule
